// ===== src/sri_pkg.sv =====
// Shared types and constants of the specular return intensity pipeline.
package sri_pkg;

    // Q1.30 unit vector component
    typedef logic signed [31:0] unit_t;

    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS  = 31;
    // range fix, squares, sum, root, quotient, sign
    localparam int NORM_LAT   = 5 + SQRT_STEPS + DIV_STEPS + 1;

    localparam int CFG_IDX_W  = 3;
    localparam logic [CFG_IDX_W-1:0] REG_EMITTER_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EMITTER_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EMITTER_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECEIVER_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RECEIVER_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RECEIVER_Z = 3'd5;

endpackage

// ===== src/specular_return_intensity.sv =====
// Top level of the specular return intensity pipeline.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_we               cfg_index, cfg_data
//   in       in         in_valid / in_stall  normal_*, hit_*, intensity_in
//   out      out        out_valid / out_stall intensity_out
//
// One transaction enters per cycle while the output is not stalled; each result passes
// through the two normalizers in series, each a 31-stage square root followed by a
// 31-stage divider. All stages advance together and hold while the output register
// holds a result under stall. Reset clears the configuration registers and valid bits.
module specular_return_intensity (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [sri_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [31:0]                           cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [15:0]                    normal_x,
    input  logic signed [15:0]                    normal_y,
    input  logic signed [15:0]                    normal_z,
    input  logic signed [31:0]                    hit_x,
    input  logic signed [31:0]                    hit_y,
    input  logic signed [31:0]                    hit_z,
    input  logic [15:0]                           intensity_in,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [15:0]                           intensity_out
);
    import sri_pkg::*;

    localparam int L_LEN   = NORM_LAT + 5;
    localparam int V_LEN   = NORM_LAT + 6;
    localparam int I_LEN   = 2 * NORM_LAT + 9;
    localparam int VLD_LEN = 2 * NORM_LAT + 10;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    logic en;

    // configuration registers
    logic signed [31:0] emit_reg [3];
    logic signed [31:0] recv_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                emit_reg[i] <= '0;
                recv_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_EMITTER_X:  emit_reg[0] <= cfg_data;
                REG_EMITTER_Y:  emit_reg[1] <= cfg_data;
                REG_EMITTER_Z:  emit_reg[2] <= cfg_data;
                REG_RECEIVER_X: recv_reg[0] <= cfg_data;
                REG_RECEIVER_Y: recv_reg[1] <= cfg_data;
                REG_RECEIVER_Z: recv_reg[2] <= cfg_data;
                default:        ;
            endcase
        end
    end

    // advance the whole pipe unless a finished transaction is held
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    logic signed [31:0] hit_in [3];
    logic signed [15:0] n_reg [3];
    logic signed [32:0] l_line [L_LEN][3];
    logic signed [32:0] v_line [V_LEN][3];
    logic [15:0]        inten_line [I_LEN];
    logic [VLD_LEN-1:0] vld_line;

    assign hit_in[0] = hit_x;
    assign hit_in[1] = hit_y;
    assign hit_in[2] = hit_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_line <= '0;
        else if (en)
            vld_line <= {vld_line[VLD_LEN-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0] <= normal_x;
            n_reg[1] <= normal_y;
            n_reg[2] <= normal_z;
            for (int i = 0; i < 3; i++)
            begin
                l_line[0][i] <= 33'(emit_reg[i]) - 33'(hit_in[i]);
                v_line[0][i] <= 33'(recv_reg[i]) - 33'(hit_in[i]);
            end
            for (int k = 1; k < L_LEN; k++)
                l_line[k] <= l_line[k-1];
            for (int k = 1; k < V_LEN; k++)
                v_line[k] <= v_line[k-1];
            inten_line[0] <= intensity_in;
            for (int k = 1; k < I_LEN; k++)
                inten_line[k] <= inten_line[k-1];
        end
    end

    // unit normal
    unit_t nu [3];

    sri_norm #(.IN_W(16)) u_norm_n (
        .clk      (clk),
        .en       (en),
        .vec_in   (n_reg),
        .unit_out (nu)
    );

    // mirror ray: M = 2 (Nu.L) Nu - L
    logic signed [63:0] pr1_reg [3];
    unit_t              nu1_reg [3];
    unit_t              nu2_reg [3];
    unit_t              nu3_reg [3];
    logic signed [63:0] d_reg;
    logic signed [33:0] dq_reg;
    logic signed [65:0] pr4_reg [3];
    logic signed [35:0] m_reg [3];
    logic [63:0]        d_mag;
    logic signed [33:0] dq_mag;
    logic [65:0]        p_mag [3];
    logic signed [35:0] mq [3];

    always_comb
    begin
        d_mag  = d_reg[63] ? 64'(-d_reg) : 64'(d_reg);
        dq_mag = $signed({1'b0, d_mag[62:30]});
        for (int i = 0; i < 3; i++)
        begin
            p_mag[i] = pr4_reg[i][65] ? 66'(-pr4_reg[i]) : 66'(pr4_reg[i]);
            mq[i]    = $signed({1'b0, p_mag[i][63:29]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                pr1_reg[i] <= nu[i] * l_line[NORM_LAT][i];
            nu1_reg <= nu;
            nu2_reg <= nu1_reg;
            nu3_reg <= nu2_reg;
            d_reg   <= pr1_reg[0] + pr1_reg[1] + pr1_reg[2];
            dq_reg  <= d_reg[63] ? -dq_mag : dq_mag;
            for (int i = 0; i < 3; i++)
            begin
                pr4_reg[i] <= dq_reg * nu3_reg[i];
                m_reg[i]   <= (pr4_reg[i][65] ? -mq[i] : mq[i])
                              - 36'(l_line[NORM_LAT+4][i]);
            end
        end
    end

    // unit mirror ray and unit view vector, side by side
    unit_t mu [3];
    unit_t vu [3];

    sri_norm #(.IN_W(36)) u_norm_m (
        .clk      (clk),
        .en       (en),
        .vec_in   (m_reg),
        .unit_out (mu)
    );

    sri_norm #(.IN_W(33)) u_norm_v (
        .clk      (clk),
        .en       (en),
        .vec_in   (v_line[NORM_LAT+5]),
        .unit_out (vu)
    );

    // cosine, clamp, scale
    logic signed [63:0] cp_reg [3];
    logic signed [63:0] c_reg;
    logic [30:0]        c30_reg;
    logic [15:0]        out_reg;
    logic [32:0]        c_hi;
    logic [46:0]        scaled;

    assign c_hi   = c_reg[62:30];
    assign scaled = inten_line[I_LEN-1] * c30_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                cp_reg[i] <= mu[i] * vu[i];
            c_reg <= cp_reg[0] + cp_reg[1] + cp_reg[2];
            if (c_reg[63] || c_reg == '0)
                c30_reg <= '0;
            else if (c_hi > 33'(ONE_Q30))
                c30_reg <= ONE_Q30;
            else
                c30_reg <= c_hi[30:0];
            out_reg <= scaled[45:30];
        end
    end

    assign out_valid     = vld_line[VLD_LEN-1];
    assign intensity_out = out_reg;

endmodule

// ===== src/sri_norm.sv =====
// Pipelined vector normalizer: range fix, sum of squares, square root, three dividers.
module sri_norm #(
    parameter int IN_W = 33
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [IN_W-1:0] vec_in [3],
    output sri_pkg::unit_t        unit_out [3]
);
    import sri_pkg::*;

    localparam int PW     = $clog2(IN_W);
    localparam int CTL_LEN = NORM_LAT - 2;

    typedef struct packed {
        logic [2:0] sgn;
        logic       zero;
    } norm_ctl_t;

    // stage 1: magnitudes and their maximum
    logic [IN_W-1:0] mag_next [3];
    logic [IN_W-1:0] mx_next;
    logic [IN_W-1:0] mag1_reg [3];
    logic [IN_W-1:0] mx1_reg;
    logic [2:0]      sgn1_reg;

    always_comb
    begin
        mx_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            mag_next[i] = vec_in[i][IN_W-1] ? IN_W'(-vec_in[i]) : IN_W'(vec_in[i]);
            if (mag_next[i] > mx_next)
                mx_next = mag_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag1_reg[i] <= mag_next[i];
                sgn1_reg[i] <= vec_in[i][IN_W-1];
            end
            mx1_reg <= mx_next;
        end
    end

    // stage 2: leading one of the maximum
    logic [PW-1:0]   p_next;
    logic [PW-1:0]   p2_reg;
    logic [IN_W-1:0] mag2_reg [3];
    norm_ctl_t       ctl_line [CTL_LEN];

    always_comb
    begin
        p_next = '0;
        for (int i = 0; i < IN_W; i++)
        begin
            if (mx1_reg[i])
                p_next = PW'(i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_reg   <= p_next;
            mag2_reg <= mag1_reg;
            ctl_line[0] <= '{sgn: sgn1_reg, zero: (mx1_reg == '0)};
            for (int k = 1; k < CTL_LEN; k++)
                ctl_line[k] <= ctl_line[k-1];
        end
    end

    // stage 3: shift all three so the largest lands in [2^29, 2^30)
    logic [IN_W+29:0] wide [3];
    logic [29:0]      m3_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            wide[i] = {30'b0, mag2_reg[i]};
            if (int'(p2_reg) >= 29)
                wide[i] = wide[i] >> (int'(p2_reg) - 29);
            else
                wide[i] = wide[i] << (29 - int'(p2_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                m3_reg[i] <= wide[i][29:0];
        end
    end

    // stages 4 and 5: squares, then their sum
    logic [59:0] sq4_reg [3];
    logic [29:0] m4_reg [3];
    logic [61:0] sum5_reg;
    logic [29:0] m5_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                sq4_reg[i] <= m3_reg[i] * m3_reg[i];
            m4_reg   <= m3_reg;
            sum5_reg <= 62'(sq4_reg[0]) + 62'(sq4_reg[1]) + 62'(sq4_reg[2]);
            m5_reg   <= m4_reg;
        end
    end

    // square root, two radicand bits per stage
    logic [33:0] sq_rem_reg  [SQRT_STEPS];
    logic [30:0] sq_root_reg [SQRT_STEPS];
    logic [61:0] sq_val_reg  [SQRT_STEPS];
    logic [29:0] sq_m_reg    [SQRT_STEPS][3];

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        logic [33:0] rem_i;
        logic [30:0] root_i;
        logic [61:0] val_i;
        logic [29:0] m_i [3];
        logic [33:0] r2;
        logic [33:0] trial;
        logic        ge;

        if (k == 0)
        begin : g_first
            assign rem_i  = '0;
            assign root_i = '0;
            assign val_i  = sum5_reg;
            assign m_i    = m5_reg;
        end
        else
        begin : g_rest
            assign rem_i  = sq_rem_reg[k-1];
            assign root_i = sq_root_reg[k-1];
            assign val_i  = sq_val_reg[k-1];
            assign m_i    = sq_m_reg[k-1];
        end

        assign r2    = {rem_i[31:0], val_i[61:60]};
        assign trial = {1'b0, root_i, 2'b01};
        assign ge    = (r2 >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rem_reg[k]  <= ge ? (r2 - trial) : r2;
                sq_root_reg[k] <= {root_i[29:0], ge};
                sq_val_reg[k]  <= {val_i[59:0], 2'b00};
                sq_m_reg[k]    <= m_i;
            end
        end
    end

    // restoring division m * 2^30 / len, one quotient bit per stage
    logic [30:0] dv_rem_reg [DIV_STEPS][3];
    logic [30:0] dv_q_reg   [DIV_STEPS][3];
    logic [30:0] dv_len_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        logic [30:0] len_i;
        logic [30:0] rem_i [3];
        logic [30:0] q_i   [3];
        logic [2:0]  bit_i;
        logic [31:0] r2    [3];
        logic [2:0]  ge;

        if (k == 0)
        begin : g_first
            assign len_i = sq_root_reg[SQRT_STEPS-1];
            for (genvar j = 0; j < 3; j++)
            begin : g_lane
                assign rem_i[j] = {2'b00, sq_m_reg[SQRT_STEPS-1][j][29:1]};
                assign q_i[j]   = '0;
                assign bit_i[j] = sq_m_reg[SQRT_STEPS-1][j][0];
            end
        end
        else
        begin : g_rest
            assign len_i = dv_len_reg[k-1];
            for (genvar j = 0; j < 3; j++)
            begin : g_lane
                assign rem_i[j] = dv_rem_reg[k-1][j];
                assign q_i[j]   = dv_q_reg[k-1][j];
                assign bit_i[j] = 1'b0;
            end
        end

        for (genvar j = 0; j < 3; j++)
        begin : g_cmp
            assign r2[j] = {rem_i[j], bit_i[j]};
            assign ge[j] = (r2[j] >= {1'b0, len_i});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_len_reg[k] <= len_i;
                for (int j = 0; j < 3; j++)
                begin
                    dv_rem_reg[k][j] <= ge[j] ? 31'(r2[j] - {1'b0, len_i}) : r2[j][30:0];
                    dv_q_reg[k][j]   <= {q_i[j][29:0], ge[j]};
                end
            end
        end
    end

    // output: restore signs, force zero for a zero-length vector
    logic signed [31:0] qs [3];
    unit_t              unit_reg [3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
            qs[j] = $signed({1'b0, dv_q_reg[DIV_STEPS-1][j]});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (ctl_line[CTL_LEN-1].zero)
                    unit_reg[j] <= '0;
                else if (ctl_line[CTL_LEN-1].sgn[j])
                    unit_reg[j] <= -qs[j];
                else
                    unit_reg[j] <= qs[j];
            end
        end
    end

    assign unit_out = unit_reg;

endmodule

// ===== test/tb_top.sv =====
// Testbench for the specular return intensity pipeline, checked by a fixed-point predictor.
`timescale 1ns / 100ps
module tb_top;
    import sri_pkg::*;

    localparam int PIPE_LAT = 2 * NORM_LAT + 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [15:0] normal_x = '0, normal_y = '0, normal_z = '0;
    logic signed [31:0] hit_x = '0, hit_y = '0, hit_z = '0;
    logic [15:0] intensity_in = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [15:0] intensity_out;

    specular_return_intensity u_top (.*);

    always #5 clk = ~clk;

    // predictor copy of the registers, Q15.16
    logic signed [31:0] emitter_pos [3];
    logic signed [31:0] receiver_pos [3];
    logic [15:0] expected_intensity [$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_receiver = 1'b0;

    function automatic longint unsigned sqrt_floor(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned abs64(longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic longint shr_trunc(longint x, int s);
        longint unsigned q;
        q = abs64(x) >> s;
        return x < 0 ? -longint'(q) : longint'(q);
    endfunction

    // unit vector in Q1.30, zero vector stays zero
    function automatic void to_unit(input longint c [3], output longint u [3]);
        longint unsigned m [3];
        longint unsigned mx, sum, len;
        mx = 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = abs64(c[i]);
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0)
        begin
            for (int i = 0; i < 3; i++) u[i] = 0;
            return;
        end
        while (mx >= (64'd1 << 30))
        begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        while (mx < (64'd1 << 29))
        begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        for (int i = 0; i < 3; i++) sum += m[i] * m[i];
        len = sqrt_floor(sum);
        for (int i = 0; i < 3; i++)
            u[i] = c[i] < 0 ? -longint'((m[i] << 30) / len) : longint'((m[i] << 30) / len);
    endfunction

    function automatic logic [15:0] predict_return(logic signed [15:0] nrm [3],
                                                   logic signed [31:0] hit [3],
                                                   logic [15:0] inten);
        longint n [3], nu [3], l [3], v [3], m [3], mu [3], vu [3];
        longint d, dq, c, c30;
        d = 0;
        c = 0;
        for (int i = 0; i < 3; i++)
        begin
            n[i] = nrm[i];
            l[i] = longint'(emitter_pos[i]) - longint'(hit[i]);
            v[i] = longint'(receiver_pos[i]) - longint'(hit[i]);
        end
        to_unit(n, nu);
        for (int i = 0; i < 3; i++) d += nu[i] * l[i];
        dq = shr_trunc(d, 30);
        for (int i = 0; i < 3; i++) m[i] = shr_trunc(dq * nu[i], 29) - l[i];
        to_unit(m, mu);
        to_unit(v, vu);
        for (int i = 0; i < 3; i++) c += mu[i] * vu[i];
        if (c <= 0) return 16'd0;
        c30 = longint'(longint'(c) >>> 30);
        if (c30 > (64'sd1 << 30)) c30 = 64'sd1 << 30;
        return 16'((longint'(inten) * c30) >>> 30);
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_EMITTER_X) emitter_pos[0] = val;
        else if (idx == REG_EMITTER_Y) emitter_pos[1] = val;
        else if (idx == REG_EMITTER_Z) emitter_pos[2] = val;
        else if (idx == REG_RECEIVER_X) receiver_pos[0] = val;
        else if (idx == REG_RECEIVER_Y) receiver_pos[1] = val;
        else if (idx == REG_RECEIVER_Z) receiver_pos[2] = val;
    endtask

    task automatic set_scene(logic [31:0] ex, ey, ez, rx, ry, rz);
        write_reg(REG_EMITTER_X, ex);
        write_reg(REG_EMITTER_Y, ey);
        write_reg(REG_EMITTER_Z, ez);
        write_reg(REG_RECEIVER_X, rx);
        write_reg(REG_RECEIVER_Y, ry);
        write_reg(REG_RECEIVER_Z, rz);
    endtask

    // called at a falling edge; returns at a falling edge after acceptance, valid left high
    task automatic send_hit(logic signed [15:0] nx, ny, nz,
                            logic signed [31:0] hx, hy, hz, logic [15:0] inten);
        logic signed [15:0] nrm [3];
        logic signed [31:0] hit [3];
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        nrm = '{nx, ny, nz};
        hit = '{hx, hy, hz};
        in_valid <= 1'b1;
        normal_x <= nx;
        normal_y <= ny;
        normal_z <= nz;
        hit_x <= hx;
        hit_y <= hy;
        hit_z <= hz;
        intensity_in <= inten;
        expected_intensity.insert(expected_intensity.size(), predict_return(nrm, hit, inten));
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // called at a falling edge; drop valid and wait for the pipe to empty
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_intensity.size() != 0) @(negedge clk);
        repeat (PIPE_LAT + 10) @(negedge clk);
    endtask

    // random scalar of a chosen scale, extremes mixed in
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom;
            default: return 32'($signed($urandom_range(20 << 16)) - (10 << 16));
        endcase
    endfunction

    function automatic logic [15:0] rand_normal();
        case ($urandom_range(4))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom);
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    task automatic send_random_hits(int count);
        for (int k = 0; k < count; k++)
            send_hit(rand_normal(), rand_normal(), rand_normal(),
                     rand_coord(), rand_coord(), rand_coord(), 16'($urandom));
    endtask

    task automatic test_directed();
        set_scene(32'h0001_0000, 32'h0002_0000, 32'h0005_0000,
                  32'hffff_0000, 32'h0002_0000, 32'h0005_0000);
        send_hit(16'h0000, 16'h0000, 16'h4000, 0, 0, 0, 16'hffff);
        send_hit(16'h0000, 16'h0000, 16'h0000, 0, 0, 0, 16'hffff);
        send_hit(16'h0000, 16'h0000, 16'h4000, 32'h0001_0000, 32'h0002_0000,
                 32'h0005_0000, 16'hffff);
        send_hit(16'h0000, 16'h0000, 16'h4000, 32'hffff_0000, 32'h0002_0000,
                 32'h0005_0000, 16'h1234);
        send_hit(16'h7fff, 16'h7fff, 16'h7fff, 0, 0, 0, 16'h0000);
        send_hit(16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 16'hffff);
        send_hit(16'h0001, 16'h0000, 16'h0000, 0, 0, 0, 16'h0001);
        send_hit(16'hffff, 16'h0001, 16'h8000, 32'h8000_0000, 32'h7fff_ffff,
                 32'h8000_0000, 16'hffff);
        send_hit(16'h0000, 16'h4000, 16'h0000, 32'h7fff_ffff, 32'h8000_0000,
                 32'h7fff_ffff, 16'h8000);
        drain();
        set_scene(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_hit(16'h4000, 16'h0000, 16'h0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 16'hffff);
        send_hit(16'h0000, 16'h0000, 16'h0000, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h7fff_ffff, 16'hffff);
        send_hit(16'h2d41, 16'h2d41, 16'h0000, 32'h8000_0000, 32'h7fff_ffff, 0, 16'h5555);
        send_hit(16'h7fff, 16'h8000, 16'h0001, 0, 0, 0, 16'haaaa);
        drain();
    endtask

    task automatic test_random_phases();
        int idle [4] = '{0, 63, 0, 11};
        int stall [4] = '{0, 0, 63, 11};
        for (int p = 0; p < 4; p++)
        begin
            set_scene(rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord());
            send_idle_pct = idle[p];
            recv_stall_pct = stall[p];
            send_random_hits(360);
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        set_scene(32'h0003_0000, 32'h0000_0000, 32'h0004_0000,
                  32'hfffd_0000, 32'h0000_0000, 32'h0004_0000);
        hold_receiver = 1'b1;
        fork
            send_random_hits(200);
            begin
                int held;
                held = 0;
                while (held < 400)
                begin
                    @(posedge clk);
                    held++;
                end
                hold_receiver = 1'b0;
            end
        join
        drain();
    endtask

    always @(negedge clk)
        out_stall <= hold_receiver || ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_intensity.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %0d", intensity_out);
            end
            else if (expected_intensity[0] !== intensity_out)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("intensity_out mismatch: expected %0d actual %0d",
                             expected_intensity[0], intensity_out);
                void'(expected_intensity.pop_front());
            end
            else
                void'(expected_intensity.pop_front());
        end

    initial
    begin
        for (int i = 0; i < 3; i++)
        begin
            emitter_pos[i] = '0;
            receiver_pos[i] = '0;
        end
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random_phases();
        test_backpressure();
        if (mismatches == 0 && expected_intensity.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb_top: errors");
        $finish;
    end
endmodule
